// ----- hdl/broadcast_fifo_three_readers_unit_macros.svh -----
// Assertion macros used by the broadcast ring buffer pointer logic.
`ifndef BROADCAST_FIFO_THREE_READERS_UNIT_MACROS_SVH
`define BROADCAST_FIFO_THREE_READERS_UNIT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define BFR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define BFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BFR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define BFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- hdl/bfr_pkg.sv -----
package bfr_pkg;

  localparam int DEPTH_DEF   = 8;
  localparam int READERS_DEF = 3;
  localparam int DATA_W      = 32;
  localparam int OCC_OUT_W   = 4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } bfr_status_t;

  // per-word decision from the pointer logic to the datapath
  typedef struct packed {
    logic                   wr_en;
    logic                   rd_en;
    bfr_status_t            status;
    logic                   freed;
    logic [OCC_OUT_W-1:0]   occupied;
  } bfr_ctl_t;

endpackage

// ----- hdl/bfr_ring_ctrl.sv -----
`include "broadcast_fifo_three_readers_unit_macros.svh"

module bfr_ring_ctrl
  import bfr_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int NUM_READERS = READERS_DEF,
  localparam int PTR_W      = $clog2(DEPTH),
  localparam int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             action,
  input  logic [1:0]       reader_id,
  output logic [PTR_W-1:0] wr_addr,
  output logic [PTR_W-1:0] rd_addr,
  output bfr_ctl_t         ctl
);

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] old_ptr_r, old_ptr_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [PTR_W-1:0] rd_ptr_r [NUM_READERS];
  logic [PTR_W-1:0] rd_ptr_nxt [NUM_READERS];
  logic [CNT_W-1:0] pend_r [NUM_READERS];
  logic [CNT_W-1:0] pend_nxt [NUM_READERS];

  logic [NUM_READERS-1:0] sel;
  logic [NUM_READERS-1:0] passed;
  logic [PTR_W-1:0]       sel_ptr;
  logic [CNT_W-1:0]       sel_pend;
  logic [3:0]             rid_ext;
  logic                   full;
  logic                   wr_ok;
  logic                   rd_ok;
  logic                   freed;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    rid_ext  = 4'(reader_id);
    full     = (occ_r == CNT_W'(DEPTH));
    sel_ptr  = '0;
    sel_pend = '0;
    for (int r = 0; r < NUM_READERS; r++) begin
      sel[r] = action && (rid_ext == 4'(r));
      if (sel[r]) begin
        sel_ptr  = sel_ptr | rd_ptr_r[r];
        sel_pend = sel_pend | pend_r[r];
      end
    end
    wr_ok = !action && !full;
    rd_ok = action && (|sel) && (sel_pend != '0);

    // oldest slot is fully read once every reader has fewer unread words
    // than there are occupied slots (counted after this read)
    for (int r = 0; r < NUM_READERS; r++) begin
      passed[r] = ((pend_r[r] - CNT_W'(sel[r])) < occ_r);
    end
    freed = rd_ok && (&passed);

    wr_ptr_nxt  = wr_ptr_r;
    old_ptr_nxt = old_ptr_r;
    occ_nxt     = occ_r;
    for (int r = 0; r < NUM_READERS; r++) begin
      rd_ptr_nxt[r] = rd_ptr_r[r];
      pend_nxt[r]   = pend_r[r];
    end
    if (wr_ok) begin
      wr_ptr_nxt = next_slot(wr_ptr_r);
      occ_nxt    = occ_r + CNT_W'(1);
      for (int r = 0; r < NUM_READERS; r++) begin
        pend_nxt[r] = pend_r[r] + CNT_W'(1);
      end
    end
    if (rd_ok) begin
      for (int r = 0; r < NUM_READERS; r++) begin
        if (sel[r]) begin
          rd_ptr_nxt[r] = next_slot(rd_ptr_r[r]);
          pend_nxt[r]   = pend_r[r] - CNT_W'(1);
        end
      end
      if (freed) begin
        old_ptr_nxt = next_slot(old_ptr_r);
        occ_nxt     = occ_r - CNT_W'(1);
      end
    end

    wr_addr      = wr_ptr_r;
    rd_addr      = sel_ptr;
    ctl.wr_en    = wr_ok;
    ctl.rd_en    = rd_ok;
    ctl.freed    = freed;
    ctl.occupied = OCC_OUT_W'(occ_nxt);
    if (action) begin
      ctl.status = rd_ok ? ST_OK : ST_EMPTY;
    end else begin
      ctl.status = full ? ST_FULL : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      old_ptr_r <= '0;
      occ_r     <= '0;
      for (int r = 0; r < NUM_READERS; r++) begin
        rd_ptr_r[r] <= '0;
        pend_r[r]   <= '0;
      end
    end else if (accept) begin
      wr_ptr_r  <= wr_ptr_nxt;
      old_ptr_r <= old_ptr_nxt;
      occ_r     <= occ_nxt;
      for (int r = 0; r < NUM_READERS; r++) begin
        rd_ptr_r[r] <= rd_ptr_nxt[r];
        pend_r[r]   <= pend_nxt[r];
      end
    end
  end

  `BFR_ASSERT_IMPL(a_occ_bound, clk, rst_n, 1'b1, occ_r <= CNT_W'(DEPTH), "occupancy over depth")
  `BFR_ASSERT_IMPL(a_freed_on_read, clk, rst_n, freed, rd_ok && (occ_r != '0), "free without read")
  `BFR_ASSERT_IMPL(a_ring_span, clk, rst_n, !full && (occ_r != '0), wr_ptr_r != old_ptr_r, "ring pointers collide")
  `BFR_ASSERT_NEXT(a_send_count, clk, rst_n, accept && wr_ok, occ_r == $past(occ_r) + CNT_W'(1), "send count")

endmodule

// ----- hdl/broadcast_fifo_three_readers_unit.sv -----
// Channel | Handshake            | Fields
// in      | in_valid, in_stall   | in_action, in_reader_id, in_msg_data
// out     | out_valid, out_stall | out_read_data, out_status, out_slot_freed, out_occupied
//
// One word per cycle unless stalled: the pointer and count update for a word
// is done when it is taken; its result is in the output register the next cycle.
// Message store read data is registered; the read address comes from the
// selected reader's pointer.
// Synchronous reset clears pointers, counts and output valid; store stays as is.
// in_stall follows out_stall while a result is held, so a stall costs no word.
module broadcast_fifo_three_readers_unit
  import bfr_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int NUM_READERS = READERS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_action,
  input  logic [1:0]               in_reader_id,
  input  logic signed [DATA_W-1:0] in_msg_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_read_data,
  output logic [1:0]               out_status,
  output logic                     out_slot_freed,
  output logic [OCC_OUT_W-1:0]     out_occupied
);

  localparam int PTR_W = $clog2(DEPTH);

  logic                     accept;
  logic [PTR_W-1:0]         wr_addr;
  logic [PTR_W-1:0]         rd_addr;
  bfr_ctl_t                 ctl;

  logic signed [DATA_W-1:0] msg_mem [DEPTH];
  logic signed [DATA_W-1:0] mem_q_r;
  logic                     out_valid_r;
  logic                     rd_ok_r;
  bfr_status_t              status_r;
  logic                     freed_r;
  logic [OCC_OUT_W-1:0]     occ_r;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  bfr_ring_ctrl #(
    .DEPTH       (DEPTH),
    .NUM_READERS (NUM_READERS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .action    (in_action),
    .reader_id (in_reader_id),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .ctl       (ctl)
  );

  always_ff @(posedge clk) begin
    if (accept && ctl.wr_en) begin
      msg_mem[wr_addr] <= in_msg_data;
    end
    if (accept && ctl.rd_en) begin
      mem_q_r <= msg_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_ok_r  <= ctl.rd_en;
      status_r <= ctl.status;
      freed_r  <= ctl.freed;
      occ_r    <= ctl.occupied;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = rd_ok_r ? mem_q_r : '0;
  assign out_status     = status_r;
  assign out_slot_freed = freed_r;
  assign out_occupied   = occ_r;

endmodule

// ----- verif/broadcast_fifo_three_readers_checker.sv -----
package ring_tb_pkg;

  typedef enum logic {
    ACT_SEND = 1'b0,
    ACT_READ = 1'b1
  } ring_action_t;

endpackage

module broadcast_fifo_three_readers_checker
  import bfr_pkg::*;
  import ring_tb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     in_action,
  input  logic [1:0]               in_reader_id,
  input  logic signed [DATA_W-1:0] in_msg_data,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [DATA_W-1:0] out_read_data,
  input  logic [1:0]               out_status,
  input  logic                     out_slot_freed,
  input  logic [OCC_OUT_W-1:0]     out_occupied,
  output int                       fail_count,
  output int                       results_waiting,
  output int                       stored,
  output int                       refused,
  output int                       delivered,
  output int                       no_unread,
  output int                       frees
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS   = DEPTH_DEF;
  localparam int READERS = READERS_DEF;
  localparam logic [READERS-1:0] ALL_READ = '1;

  typedef struct packed {
    logic [DATA_W-1:0]    read_data;
    bfr_status_t          status;
    logic                 freed;
    logic [OCC_OUT_W-1:0] occupied;
  } ring_result_t;

  logic [DATA_W-1:0]  slot_data  [SLOTS];
  logic [READERS-1:0] slot_marks [SLOTS];
  int                 head_slot;
  int                 oldest_slot;
  int                 fill;
  int                 reader_slot   [READERS];
  int                 reader_unread [READERS];
  ring_result_t       expected_q [$];

  function automatic int wrap_next(input int p);
    return (p + 1 == SLOTS) ? 0 : p + 1;
  endfunction

  // Advances the ring model by one word and returns the result it must produce.
  task automatic apply_word(input ring_action_t act, input logic [1:0] rid,
                            input logic [DATA_W-1:0] data, output ring_result_t res);
    int p;
    res.read_data = '0;
    res.status    = ST_OK;
    res.freed     = 1'b0;
    if (act == ACT_SEND) begin
      if (fill >= SLOTS) begin
        res.status = ST_FULL;
        refused++;
      end else begin
        slot_data[head_slot]  = data;
        slot_marks[head_slot] = '0;
        head_slot = wrap_next(head_slot);
        fill++;
        foreach (reader_unread[i]) reader_unread[i]++;
        stored++;
      end
    end else if (int'(rid) >= READERS || reader_unread[rid] == 0) begin
      // out-of-range reader or reader already caught up: no stale data
      res.status = ST_EMPTY;
      no_unread++;
    end else begin
      p = reader_slot[rid];
      res.read_data = slot_data[p];
      slot_marks[p][rid] = 1'b1;
      reader_slot[rid] = wrap_next(p);
      reader_unread[rid]--;
      if (fill > 0 && slot_marks[oldest_slot] == ALL_READ) begin
        slot_marks[oldest_slot] = '0;
        oldest_slot = wrap_next(oldest_slot);
        fill--;
        res.freed = 1'b1;
        frees++;
      end
      delivered++;
    end
    res.occupied = fill[OCC_OUT_W-1:0];
  endtask

  always @(posedge clk) begin : track
    ring_result_t got;
    ring_result_t want;
    if (!rst_n) begin
      foreach (slot_marks[i]) slot_marks[i] = '0;
      foreach (reader_slot[i]) begin
        reader_slot[i]   = 0;
        reader_unread[i] = 0;
      end
      head_slot   = 0;
      oldest_slot = 0;
      fill        = 0;
      expected_q.delete();
      fail_count = 0;
      stored     = 0;
      refused    = 0;
      delivered  = 0;
      no_unread  = 0;
      frees      = 0;
      results_waiting <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.read_data = out_read_data;
        got.status    = bfr_status_t'(out_status);
        got.freed     = out_slot_freed;
        got.occupied  = out_occupied;
        if (expected_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result word with nothing expected: data %h status %0d freed %b occ %0d",
                     $realtime, out_read_data, out_status, out_slot_freed, out_occupied);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("%0t: mismatch: expected data %h status %s freed %b occ %0d, got data %h status %0d freed %b occ %0d",
                       $realtime, want.read_data, want.status.name(), want.freed, want.occupied,
                       out_read_data, out_status, out_slot_freed, out_occupied);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_word(ring_action_t'(in_action), in_reader_id, in_msg_data, want);
        expected_q.push_back(want);
      end
      // registered so the stimulus side sees a stable count after each edge
      results_waiting <= expected_q.size();
    end
  end

endmodule

// ----- verif/broadcast_fifo_three_readers_unit_tb.sv -----
module broadcast_fifo_three_readers_unit_tb
  import bfr_pkg::*, ring_tb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_WORDS = 1200;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_action;
  logic [1:0]               in_reader_id;
  logic signed [DATA_W-1:0] in_msg_data;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] out_read_data;
  logic [1:0]               out_status;
  logic                     out_slot_freed;
  logic [OCC_OUT_W-1:0]     out_occupied;

  int fail_count;
  int results_waiting;
  int stored;
  int refused;
  int delivered;
  int no_unread;
  int frees;

  bit calm = 1'b0;

  broadcast_fifo_three_readers_unit DUT (.*);

  broadcast_fifo_three_readers_checker ring_check (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= !calm && ($urandom_range(99) < 22);
    end
  end

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Presents one word and returns at the edge that takes it.
  task automatic issue(input ring_action_t act, input logic [1:0] rid,
                       input logic [DATA_W-1:0] data);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_reader_id <= rid;
    in_msg_data  <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_waiting != 0);
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    logic [DATA_W-1:0] edge_words [8];
    logic [1:0]        rid;
    int                counted;
    int                send_pct;
    int                lag;
    int                burst;
    bit                drained_mid;

    edge_words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                   32'h5555_AAAA, 32'hAAAA_5555, 32'h0000_0001, 32'hFFFF_FFFE};
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_action    <= ACT_SEND;
    in_reader_id <= '0;
    in_msg_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reads on an empty ring, including the out-of-range reader id
    for (int r = 0; r < 4; r++) issue(ACT_READ, 2'(r), pick_word());
    issue(ACT_SEND, 2'd1, 32'h1234_5678);
    issue(ACT_READ, 2'd0, pick_word());
    issue(ACT_READ, 2'd0, pick_word());   // reader 0 caught up
    issue(ACT_READ, 2'd1, pick_word());
    issue(ACT_READ, 2'd2, pick_word());   // last reader frees the slot
    foreach (edge_words[i]) issue(ACT_SEND, 2'(i), edge_words[i]);
    issue(ACT_SEND, 2'd2, 32'hDEAD_BEEF); // ring full
    issue(ACT_READ, 2'd3, pick_word());
    for (int r = 0; r < READERS_DEF; r++) issue(ACT_READ, 2'(r), pick_word());
    issue(ACT_SEND, 2'd3, 32'h0BAD_F00D);
    wait_for_drain();

    // bursts with a send/read bias each, one reader often left lagging
    counted     = 0;
    drained_mid = 1'b0;
    while (counted < RANDOM_WORDS) begin
      case ($urandom_range(4))
        0:       send_pct = 10;
        1:       send_pct = 35;
        2:       send_pct = 50;
        3:       send_pct = 65;
        default: send_pct = 90;
      endcase
      lag   = $urandom_range(READERS_DEF);
      burst = $urandom_range(60, 10);
      repeat (burst) begin
        if ($urandom_range(99) < send_pct) begin
          issue(ACT_SEND, 2'($urandom_range(3)), pick_word());
          counted++;
        end else begin
          if ($urandom_range(99) < 5)
            rid = 2'(READERS_DEF);
          else
            rid = 2'($urandom_range(READERS_DEF - 1));
          if (int'(rid) == lag) rid = 2'($urandom_range(READERS_DEF - 1));
          issue(ACT_READ, rid, pick_word());
          if (int'(rid) < READERS_DEF) counted++;
        end
      end
      calm = (counted >= 400 && counted < 700);
      if (!drained_mid && counted >= 800) begin
        drained_mid = 1'b1;
        wait_for_drain();
      end
    end

    wait_for_drain();
    repeat (8) @(posedge clk);

    $display("Covered %0d words: %0d sends stored, %0d sends refused on a full ring,",
             stored + refused + delivered + no_unread, stored, refused);
    $display("%0d reads delivered, %0d reads with nothing unread, %0d slots freed.",
             delivered, no_unread, frees);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
